>>> rtl/interval_set_merge_table_assert.svh
// ----------------------------------------------------------------------------
// interval_set_merge_table assertion macros
// Shared concurrent assertion forms, sampled on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SET_MERGE_TABLE_ASSERT_SVH
`define INTERVAL_SET_MERGE_TABLE_ASSERT_SVH

// same-cycle implication
`define ISMT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ismt_pkg.sv
// ----------------------------------------------------------------------------
// ismt_pkg
// Opcodes, status codes, sequencer states and the table entry type of the
// interval set merge table.
// ----------------------------------------------------------------------------
`default_nettype none

package ismt_pkg;

  // request opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH,
    S_RESP
  } state_t;

  // one stored interval [ent_start, ent_end)
  typedef struct packed {
    logic [63:0] ent_start;
    logic [63:0] ent_end;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/interval_set_merge_table.sv
// ----------------------------------------------------------------------------
// interval_set_merge_table
// Sorted table of disjoint half-open address intervals with merging insert,
// point lookup and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_* carries one request (opcode, addr_lo, addr_hi); it is
//   taken when in_valid is high and in_stall low. Every request returns one
//   result on out_* (hit, found_start, found_end, status), taken when
//   out_valid is high and out_stall low.
//   One request is worked at a time; in_stall is high until it is finished.
//   The table sits in a two-bank memory with one read and one write port.
//   Each stored entry is read, then compared in the shared compare unit. An
//   insert scans every stored entry, with one more compare step when the new
//   interval lands before a stored entry; a lookup stops at its first hit;
//   an empty insert or a clear goes straight to the result.
//   An insert streams the old bank into the other bank and switches banks
//   only when it succeeds, so a refused insert leaves the table intact.
//   A finished result waits in the output register while out_stall is high;
//   the next request is taken meanwhile and holds until that register frees.
//   Synchronous active-low reset empties the table and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_merge_table #(
  parameter int CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_opcode,
  input  wire  [63:0] in_addr_lo,
  input  wire  [63:0] in_addr_hi,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_hit,
  output logic [63:0] out_found_start,
  output logic [63:0] out_found_end,
  output logic [1:0]  out_status
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WR_W   = $clog2(CAPACITY + 2);
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 * (2 ** IDX_W);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // control registers
  ismt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             bank_r, bank_nxt;
  logic             out_valid_r, out_valid_nxt;

  // request and working registers
  logic [1:0]       op_r, op_nxt;
  logic [63:0]      lo_r, lo_nxt;
  logic [63:0]      hi_r, hi_nxt;
  logic [63:0]      ns_r, ns_nxt;
  logic [63:0]      ne_r, ne_nxt;
  logic             merged_r, merged_nxt;
  logic             placed_r, placed_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [WR_W-1:0]  wr_cnt_r, wr_cnt_nxt;

  // pending result and output registers
  logic             res_hit_r, res_hit_nxt;
  logic [63:0]      res_start_r, res_start_nxt;
  logic [63:0]      res_end_r, res_end_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [63:0]      out_start_r, out_start_nxt;
  logic [63:0]      out_end_r, out_end_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  // table memory, two banks of 2**IDX_W slots
  ismt_pkg::entry_t tbl_mem [DEPTH];
  ismt_pkg::entry_t rd_q_r;
  logic             mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa;
  ismt_pkg::entry_t mem_wd;

  // shared compare unit signals
  logic [63:0] cmp_key;
  logic        start_le_key;
  logic        end_ge_lo;
  logic        end_gt_lo;
  logic        start_lt_ns;
  logic        end_gt_ne;
  logic        ent_merge;
  logic        ent_before;
  logic        is_last;
  logic        out_free;
  logic        overflow;

  assign in_stall        = (state_r != ismt_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_start = out_start_r;
  assign out_found_end   = out_end_r;
  assign out_status      = out_status_r;

  assign out_free = !out_valid_r || !out_stall;

  // compare unit on the entry just read
  assign cmp_key      = (op_r == ismt_pkg::OP_LOOKUP) ? lo_r : hi_r;
  assign start_le_key = (rd_q_r.ent_start <= cmp_key);
  assign end_ge_lo    = (rd_q_r.ent_end >= lo_r);
  assign end_gt_lo    = (rd_q_r.ent_end > lo_r);
  assign start_lt_ns  = (rd_q_r.ent_start < ns_r);
  assign end_gt_ne    = (rd_q_r.ent_end > ne_r);
  assign ent_merge    = start_le_key && end_ge_lo;
  assign ent_before   = !end_ge_lo;
  assign is_last      = (rd_cnt_r == (count_r - 1'b1));
  assign overflow     = !merged_r && (count_r == CAP_CNT);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ismt_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            ismt_pkg::OP_INSERT: begin
              if (in_addr_lo >= in_addr_hi) begin
                state_nxt = ismt_pkg::S_RESP;
              end else if (count_r == '0) begin
                state_nxt = ismt_pkg::S_FINISH;
              end else begin
                state_nxt = ismt_pkg::S_READ;
              end
            end
            ismt_pkg::OP_LOOKUP: begin
              state_nxt = (count_r == '0) ? ismt_pkg::S_RESP : ismt_pkg::S_READ;
            end
            default: state_nxt = ismt_pkg::S_RESP;
          endcase
        end
      end
      ismt_pkg::S_READ: state_nxt = ismt_pkg::S_EVAL;
      ismt_pkg::S_EVAL: begin
        if (op_r == ismt_pkg::OP_LOOKUP) begin
          if (ent_merge && end_gt_lo) begin
            state_nxt = ismt_pkg::S_RESP;
          end else begin
            state_nxt = is_last ? ismt_pkg::S_RESP : ismt_pkg::S_READ;
          end
        end else if (!ent_merge && !ent_before && !placed_r) begin
          state_nxt = ismt_pkg::S_EVAL;
        end else begin
          state_nxt = is_last ? ismt_pkg::S_FINISH : ismt_pkg::S_READ;
        end
      end
      ismt_pkg::S_FINISH: state_nxt = ismt_pkg::S_RESP;
      ismt_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = ismt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ismt_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_nxt      = count_r;
    bank_nxt       = bank_r;
    op_nxt         = op_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    ns_nxt         = ns_r;
    ne_nxt         = ne_r;
    merged_nxt     = merged_r;
    placed_nxt     = placed_r;
    rd_cnt_nxt     = rd_cnt_r;
    wr_cnt_nxt     = wr_cnt_r;
    res_hit_nxt    = res_hit_r;
    res_start_nxt  = res_start_r;
    res_end_nxt    = res_end_r;
    res_status_nxt = res_status_r;
    out_hit_nxt    = out_hit_r;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_re         = 1'b0;
    mem_ra         = {bank_r, rd_cnt_r[IDX_W-1:0]};
    mem_we         = 1'b0;
    mem_wa         = {!bank_r, wr_cnt_r[IDX_W-1:0]};
    mem_wd         = '{ent_start: ns_r, ent_end: ne_r};

    unique case (state_r)
      // take a request and set up the scan
      ismt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_opcode;
          lo_nxt         = in_addr_lo;
          hi_nxt         = in_addr_hi;
          ns_nxt         = in_addr_lo;
          ne_nxt         = in_addr_hi;
          merged_nxt     = 1'b0;
          placed_nxt     = 1'b0;
          rd_cnt_nxt     = '0;
          wr_cnt_nxt     = '0;
          res_hit_nxt    = 1'b0;
          res_start_nxt  = '0;
          res_end_nxt    = '0;
          res_status_nxt = ismt_pkg::ST_DONE;
          if (in_opcode == ismt_pkg::OP_INSERT && in_addr_lo >= in_addr_hi) begin
            res_status_nxt = ismt_pkg::ST_EMPTY;
          end
          if (in_opcode == ismt_pkg::OP_CLEAR) begin
            count_nxt = '0;
          end
        end
      end
      // fetch the next stored entry
      ismt_pkg::S_READ: begin
        mem_re = 1'b1;
      end
      // classify the fetched entry
      ismt_pkg::S_EVAL: begin
        if (op_r == ismt_pkg::OP_LOOKUP) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          if (ent_merge && end_gt_lo) begin
            res_hit_nxt   = 1'b1;
            res_start_nxt = rd_q_r.ent_start;
            res_end_nxt   = rd_q_r.ent_end;
          end
        end else if (ent_merge) begin
          merged_nxt = 1'b1;
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          if (start_lt_ns) begin
            ns_nxt = rd_q_r.ent_start;
          end
          if (end_gt_ne) begin
            ne_nxt = rd_q_r.ent_end;
          end
        end else if (ent_before || placed_r) begin
          mem_we     = 1'b1;
          mem_wd     = rd_q_r;
          wr_cnt_nxt = wr_cnt_r + 1'b1;
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end else begin
          // first entry past the union: place the union, keep this entry
          mem_we     = 1'b1;
          wr_cnt_nxt = wr_cnt_r + 1'b1;
          placed_nxt = 1'b1;
        end
      end
      // commit the insert or refuse it
      ismt_pkg::S_FINISH: begin
        if (overflow) begin
          res_status_nxt = ismt_pkg::ST_FULL;
        end else begin
          bank_nxt = !bank_r;
          if (placed_r) begin
            count_nxt = CNT_W'(wr_cnt_r);
          end else begin
            mem_we    = 1'b1;
            count_nxt = CNT_W'(wr_cnt_r + 1'b1);
          end
        end
      end
      // hand the result to the output register
      ismt_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = res_hit_r;
          out_start_nxt  = res_start_r;
          out_end_nxt    = res_end_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  // table memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= tbl_mem[mem_ra];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ismt_pkg::S_IDLE;
      count_r     <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    ns_r         <= ns_nxt;
    ne_r         <= ne_nxt;
    merged_r     <= merged_nxt;
    placed_r     <= placed_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    wr_cnt_r     <= wr_cnt_nxt;
    res_hit_r    <= res_hit_nxt;
    res_start_r  <= res_start_nxt;
    res_end_r    <= res_end_nxt;
    res_status_r <= res_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_start_r  <= out_start_nxt;
    out_end_r    <= out_end_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/ismt_chk.sv
// ----------------------------------------------------------------------------
// ismt_chk
// Port-level checks of the interval set merge table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interval_set_merge_table_assert.svh"

module ismt_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire        out_hit,
  input wire [63:0] out_found_start,
  input wire [63:0] out_found_end,
  input wire [1:0]  out_status
);

  logic hit_ok;
  logic miss_ok;

  // shape of a hit and of a miss
  assign hit_ok  = (out_status == ismt_pkg::ST_DONE) && (out_found_start < out_found_end);
  assign miss_ok = (out_found_start == 64'd0) && (out_found_end == 64'd0);

  // a stalled result stays offered
  `ISMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

  // a taken request keeps the block busy in the next cycle
  `ISMT_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "busy not raised")

  // a hit is always a completed lookup on a non-empty interval
  `ISMT_ASSERT_SAME(a_hit_bounds, out_valid && out_hit, hit_ok, "bad hit result")

  // a miss reports zero bounds
  `ISMT_ASSERT_SAME(a_miss_zero, out_valid && !out_hit, miss_ok, "miss with bounds")

endmodule

bind interval_set_merge_table ismt_chk u_ismt_chk (.*);

`default_nettype wire

>>> tb/interval_set_merge_table_tb.sv
// ----------------------------------------------------------------------------
// interval_set_merge_table_tb
// Drives insert, lookup and clear requests into the interval table and checks
// every result against a typed result or a cycle-free table model kept in
// the bench. A directed table covers empty and touching intervals and the
// address extremes. A fill to capacity covers the refused insert. Random
// traffic then works in address zones, so that merges, full tables and hits
// are common. Sender bursts and receiver stall patterns vary throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_merge_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int PAUSE_EVERY   = 300;
  localparam int LONG_HOLD     = 200;
  localparam int HOLD_PERIOD   = 5000;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int DIR_ROWS      = 25;
  localparam logic [63:0] ADDR_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        hit;
    logic [63:0] found_start;
    logic [63:0] found_end;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] addr_lo;
    logic [63:0] addr_hi;
    logic        has_want;
    result_t     want;
  } dir_row_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

  localparam result_t NO_WANT = '0;
  localparam result_t R_DONE  = '{1'b0, 64'd0, 64'd0, ismt_pkg::ST_DONE};
  localparam result_t R_EMPTY = '{1'b0, 64'd0, 64'd0, ismt_pkg::ST_EMPTY};

  // directed requests; a typed result where it is obvious, else the model decides
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ismt_pkg::OP_LOOKUP, 64'd0,        64'd0,    1'b1, R_DONE},
    '{ismt_pkg::OP_INSERT, 64'd10,       64'd5,    1'b1, R_EMPTY},
    '{ismt_pkg::OP_INSERT, 64'd7,        64'd7,    1'b1, R_EMPTY},
    '{ismt_pkg::OP_INSERT, ADDR_MAX,     ADDR_MAX, 1'b1, R_EMPTY},
    '{ismt_pkg::OP_INSERT, ADDR_MAX,     64'd0,    1'b1, R_EMPTY},
    '{ismt_pkg::OP_INSERT, 64'd100,      64'd200,  1'b1, R_DONE},
    '{ismt_pkg::OP_LOOKUP, 64'd150,      ADDR_MAX, 1'b1,
      '{1'b1, 64'd100, 64'd200, ismt_pkg::ST_DONE}},
    '{ismt_pkg::OP_LOOKUP, 64'd200,      64'd0,    1'b1, R_DONE},
    '{ismt_pkg::OP_LOOKUP, 64'd99,       64'd0,    1'b1, R_DONE},
    '{ismt_pkg::OP_INSERT, 64'd200,      64'd300,  1'b0, NO_WANT},
    '{ismt_pkg::OP_INSERT, 64'd50,       64'd100,  1'b0, NO_WANT},
    '{ismt_pkg::OP_LOOKUP, 64'd50,       64'd0,    1'b0, NO_WANT},
    '{ismt_pkg::OP_INSERT, 64'd400,      64'd500,  1'b0, NO_WANT},
    '{ismt_pkg::OP_INSERT, 64'd600,      64'd700,  1'b0, NO_WANT},
    '{ismt_pkg::OP_INSERT, 64'd320,      64'd330,  1'b0, NO_WANT},
    '{ismt_pkg::OP_INSERT, 64'd250,      64'd650,  1'b0, NO_WANT},
    '{ismt_pkg::OP_LOOKUP, 64'd649,      64'd0,    1'b0, NO_WANT},
    '{ismt_pkg::OP_CLEAR,  ADDR_MAX,     ADDR_MAX, 1'b1, R_DONE},
    '{ismt_pkg::OP_LOOKUP, 64'd150,      64'd0,    1'b1, R_DONE},
    '{ismt_pkg::OP_INSERT, 64'd0,        ADDR_MAX, 1'b1, R_DONE},
    '{ismt_pkg::OP_LOOKUP, ADDR_MAX - 1, 64'd0,    1'b1,
      '{1'b1, 64'd0, ADDR_MAX, ismt_pkg::ST_DONE}},
    '{ismt_pkg::OP_LOOKUP, ADDR_MAX,     64'd0,    1'b1, R_DONE},
    '{ismt_pkg::OP_CLEAR,  64'd0,        64'd0,    1'b1, R_DONE},
    '{ismt_pkg::OP_INSERT, ADDR_MAX - 1, ADDR_MAX, 1'b1, R_DONE},
    '{ismt_pkg::OP_LOOKUP, ADDR_MAX - 1, 64'd0,    1'b1,
      '{1'b1, ADDR_MAX - 1, ADDR_MAX, ismt_pkg::ST_DONE}}
  };

  // dut signals
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = ismt_pkg::OP_LOOKUP;
  logic [63:0] in_addr_lo = '0;
  logic [63:0] in_addr_hi = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_hit;
  logic [63:0] out_found_start;
  logic [63:0] out_found_end;
  logic [1:0]  out_status;

  // bench model of the interval table
  logic [63:0] held_start [TABLE_DEPTH];
  logic [63:0] held_end [TABLE_DEPTH];
  int          held_count = 0;

  result_t     pending_results [$];
  result_t     oldest;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_len = 0;
  logic [63:0] zone_base = '0;

  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_left = 0;
  int          hold_timer = 1500;

  always #10 clk = ~clk;

  interval_set_merge_table #(
    .CAPACITY(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_addr_lo(in_addr_lo),
    .in_addr_hi(in_addr_hi),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hit(out_hit),
    .out_found_start(out_found_start),
    .out_found_end(out_found_end),
    .out_status(out_status)
  );

  // apply one request to the table model and return its result
  function automatic result_t apply_request(logic [1:0] op, logic [63:0] lo,
                                            logic [63:0] hi);
    result_t     res;
    logic [63:0] u_lo;
    logic [63:0] u_hi;
    int          touching;
    int          keep;
    int          pos;
    res = '0;
    case (op)
      ismt_pkg::OP_INSERT: begin
        if (lo >= hi) begin
          res.status = ismt_pkg::ST_EMPTY;
        end else begin
          touching = 0;
          for (int i = 0; i < held_count; i++)
            if (held_start[i] <= hi && held_end[i] >= lo) touching++;
          if (touching == 0 && held_count >= TABLE_DEPTH) begin
            res.status = ismt_pkg::ST_FULL;
          end else begin
            // widen to the union and compact the untouched entries
            u_lo = lo;
            u_hi = hi;
            keep = 0;
            for (int i = 0; i < held_count; i++) begin
              if (held_start[i] <= hi && held_end[i] >= lo) begin
                if (held_start[i] < u_lo) u_lo = held_start[i];
                if (held_end[i] > u_hi) u_hi = held_end[i];
              end else begin
                held_start[keep] = held_start[i];
                held_end[keep] = held_end[i];
                keep++;
              end
            end
            // open a slot at the sorted position
            pos = 0;
            while (pos < keep && held_start[pos] < u_lo) pos++;
            for (int i = keep; i > pos; i--) begin
              held_start[i] = held_start[i - 1];
              held_end[i] = held_end[i - 1];
            end
            held_start[pos] = u_lo;
            held_end[pos] = u_hi;
            held_count = keep + 1;
            res.status = ismt_pkg::ST_DONE;
          end
        end
      end
      ismt_pkg::OP_LOOKUP: begin
        for (int i = 0; i < held_count; i++) begin
          if (!res.hit && held_start[i] <= lo && lo < held_end[i]) begin
            res.hit = 1'b1;
            res.found_start = held_start[i];
            res.found_end = held_end[i];
          end
        end
      end
      ismt_pkg::OP_CLEAR: held_count = 0;
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // a point on or next to a bound of a stored interval
  function automatic logic [63:0] near_point();
    int k;
    k = $urandom_range(0, held_count - 1);
    case ($urandom_range(0, 3))
      0: return held_start[k];
      1: return held_end[k] - 1;
      2: return held_end[k];
      default: return held_start[k] - 1;
    endcase
  endfunction

  // new address zone: bottom, anywhere, or just under the top
  function automatic logic [63:0] new_zone();
    case ($urandom_range(0, 3))
      0, 1: return 64'd0;
      2: return rand_addr();
      default: return ADDR_MAX - 64'($urandom_range(0, 700));
    endcase
  endfunction

  // random request, mostly within the current zone
  task automatic pick_request(output logic [1:0] op, output logic [63:0] lo,
                              output logic [63:0] hi);
    int r;
    int k;
    r = $urandom_range(0, 99);
    lo = rand_addr();
    hi = rand_addr();
    if (r < 3) begin
      op = ismt_pkg::OP_CLEAR;
      zone_base = new_zone();
    end else if (r < 58) begin
      op = ismt_pkg::OP_INSERT;
      case ($urandom_range(0, 19))
        0: ;
        1: begin
          lo = zone_base + 64'($urandom_range(0, 600));
          hi = lo;
        end
        2: begin
          hi = zone_base + 64'($urandom_range(0, 600));
          lo = hi + 64'($urandom_range(1, 50));
        end
        3, 4, 5: begin
          lo = zone_base + 64'($urandom_range(0, 600));
          hi = lo + 64'($urandom_range(20, 150));
        end
        6, 7: begin
          // butt up against a stored interval from either side
          if (held_count > 0) begin
            k = $urandom_range(0, held_count - 1);
            if ($urandom_range(0, 1) == 0) begin
              lo = held_end[k];
              hi = lo + 64'($urandom_range(1, 10));
            end else begin
              hi = held_start[k];
              lo = hi - 64'($urandom_range(1, 10));
            end
          end else begin
            lo = zone_base + 64'($urandom_range(0, 600));
            hi = lo + 64'($urandom_range(1, 12));
          end
        end
        default: begin
          lo = zone_base + 64'($urandom_range(0, 600));
          hi = lo + 64'($urandom_range(1, 12));
        end
      endcase
    end else begin
      op = ismt_pkg::OP_LOOKUP;
      r = $urandom_range(0, 99);
      if (r < 60 && held_count > 0) lo = near_point();
      else if (r < 95) lo = zone_base + 64'($urandom_range(0, 700));
    end
  endtask

  // offer one request in bursts with random gaps, record its result once taken
  task automatic offer(input logic [1:0] op, input logic [63:0] lo,
                       input logic [63:0] hi, input logic has_want,
                       input result_t want);
    result_t modeled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_addr_lo <= lo;
    in_addr_hi <= hi;
    do @(posedge clk); while (in_stall);
    modeled = apply_request(op, lo, hi);
    pending_results.push_back(has_want ? want : modeled);
  endtask

  // stop sending until every outstanding result is back
  task automatic drain_results();
    if (pending_results.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  // receiver stall patterns, with a long hold-off now and then
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_timer == 0) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_timer <= HOLD_PERIOD;
    end else begin
      hold_timer <= hold_timer - 1;
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
        out_stall <= 1'b0;
      end else begin
        mode_left <= mode_left - 1;
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
        endcase
      end
    end
  end

  // compare each taken result with the oldest outstanding one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: hit %0b status %0d",
               out_hit, out_status);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_hit !== oldest.hit) begin
          $error("hit: expected %0b, actual %0b", oldest.hit, out_hit);
          mismatches++;
        end
        if (out_found_start !== oldest.found_start) begin
          $error("found_start: expected %h, actual %h", oldest.found_start,
                 out_found_start);
          mismatches++;
        end
        if (out_found_end !== oldest.found_end) begin
          $error("found_end: expected %h, actual %h", oldest.found_end, out_found_end);
          mismatches++;
        end
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [1:0]  op;
    logic [63:0] lo;
    logic [63:0] hi;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < DIR_ROWS; n++)
      offer(DIR_TABLE[n].opcode, DIR_TABLE[n].addr_lo, DIR_TABLE[n].addr_hi,
            DIR_TABLE[n].has_want, DIR_TABLE[n].want);
    drain_results();

    // fill to capacity, one refused insert, then a merge while full
    offer(ismt_pkg::OP_CLEAR, 64'd0, 64'd0, 1'b0, NO_WANT);
    for (int k = 0; k <= TABLE_DEPTH; k++)
      offer(ismt_pkg::OP_INSERT, 64'(k * 16), 64'(k * 16 + 4), 1'b0, NO_WANT);
    offer(ismt_pkg::OP_INSERT, 64'd4, 64'd8, 1'b0, NO_WANT);
    offer(ismt_pkg::OP_LOOKUP, 64'd6, 64'd0, 1'b0, NO_WANT);
    offer(ismt_pkg::OP_CLEAR, 64'd0, 64'd0, 1'b0, NO_WANT);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PAUSE_EVERY == PAUSE_EVERY - 1) drain_results();
      pick_request(op, lo, hi);
      offer(op, lo, hi, 1'b0, NO_WANT);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
